### rtl/ready_blocked_job_scheduler_assert.svh
// Assertion macros for the ready/blocked job scheduler.
// Used by the top level only; needs no package.
`ifndef READY_BLOCKED_JOB_SCHEDULER_ASSERT_SVH
`define READY_BLOCKED_JOB_SCHEDULER_ASSERT_SVH
// An implication that must hold whenever reset is released.
`define RBJS_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// A next-cycle implication.
`define RBJS_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

### rtl/rbjs_pkg.sv
// Shared types and opcodes of the ready/blocked job scheduler.
// No dependencies.
package rbjs_pkg;
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_BLOCK = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // Command handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  tag;
        logic [31:0] cpu;
        logic [31:0] io;
    } t_cmd;
endpackage

### rtl/rbjs_front.sv
// Front part: accepts input beats and queues them as commands.
// Depends on rbjs_pkg.
module rbjs_front import rbjs_pkg::*; #(
    parameter int TIME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_job_tag,
    input  logic [15:0] i_cpu_time,
    input  logic [15:0] i_io_time,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_take
);
    // Two-entry queue.
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd;

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd     = '0;
        cmd.op  = i_opcode;
        cmd.tag = i_job_tag;
        // Stored times keep only the low TIME_BITS bits.
        cmd.cpu = {16'd0, i_cpu_time} & ((32'd1 << TIME_BITS) - 32'd1);
        cmd.io  = {16'd0, i_io_time} & ((32'd1 << TIME_BITS) - 32'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd;
                r_wp      <= ~r_wp;
            end
            if (i_cmd_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_take};
        end
    end
endmodule

### rtl/rbjs_back.sv
// Back part: holds the ready and blocked stores and carries out commands.
// Depends on rbjs_pkg.
module rbjs_back import rbjs_pkg::*; #(
    parameter int MAX_JOBS  = 16,
    parameter int TIME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_take,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_job_count,
    output logic [19:0] o_total_cpu,
    output logic        o_finished_valid,
    output logic [7:0]  o_finished_tag,
    output logic        o_rejected
);
    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int SW = TIME_BITS + CW;

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT, S_SCAN, S_SUM_R, S_SUM_B, S_OUT
    } t_state;

    logic [7:0]           r_rtag [MAX_JOBS];
    logic [TIME_BITS-1:0] r_rcpu [MAX_JOBS];
    logic [TIME_BITS-1:0] r_rio  [MAX_JOBS];
    logic [7:0]           r_btag [MAX_JOBS];
    logic [TIME_BITS-1:0] r_bcpu [MAX_JOBS];
    logic [TIME_BITS-1:0] r_bio  [MAX_JOBS];
    logic [CW-1:0]        r_rcnt, r_bcnt;

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [CW-1:0]        r_i, r_kept;
    logic [SW-1:0]        r_sum;
    logic                 r_fin, r_rej;
    logic [7:0]           r_ftag;
    logic [TIME_BITS-1:0] w_io;

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign w_io = (r_bio[r_i[IW-1:0]] != '0) ? r_bio[r_i[IW-1:0]] - 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rcnt  <= '0;
            r_bcnt  <= '0;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_cmd_valid) begin
                    r_cmd  <= i_cmd;
                    r_fin  <= 1'b0;
                    r_ftag <= '0;
                    r_rej  <= 1'b0;
                    r_i    <= '0;
                    r_kept <= '0;
                    r_sum  <= '0;
                    r_state <= S_SUM_R;
                    unique case (i_cmd.op)
                        OP_ADD: begin
                            if (r_rcnt + r_bcnt >= CW'(MAX_JOBS)) r_rej <= 1'b1;
                            else begin
                                r_rtag[r_rcnt[IW-1:0]] <= i_cmd.tag;
                                r_rcpu[r_rcnt[IW-1:0]] <= i_cmd.cpu[TIME_BITS-1:0];
                                r_rio[r_rcnt[IW-1:0]]  <= i_cmd.io[TIME_BITS-1:0];
                                r_rcnt <= r_rcnt + 1'b1;
                            end
                        end
                        OP_BLOCK: begin
                            if (r_rcnt == '0) r_rej <= 1'b1;
                            else begin
                                r_btag[r_bcnt[IW-1:0]] <= r_rtag[0];
                                r_bcpu[r_bcnt[IW-1:0]] <= r_rcpu[0];
                                r_bio[r_bcnt[IW-1:0]]  <= r_rio[0];
                                r_bcnt  <= r_bcnt + 1'b1;
                                r_i     <= CW'(1);
                                r_state <= S_SHIFT;
                            end
                        end
                        OP_TICK: begin
                            r_state <= S_SCAN;
                            if (r_rcnt != '0) begin
                                if (r_rcpu[0] <= TIME_BITS'(1)) begin
                                    r_fin   <= 1'b1;
                                    r_ftag  <= r_rtag[0];
                                    r_i     <= CW'(1);
                                    r_state <= S_SHIFT;
                                end else r_rcpu[0] <= r_rcpu[0] - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SHIFT: begin
                    // One entry a cycle moves towards the ready head.
                    if (r_i < r_rcnt) begin
                        r_rtag[r_i[IW-1:0]-1'b1] <= r_rtag[r_i[IW-1:0]];
                        r_rcpu[r_i[IW-1:0]-1'b1] <= r_rcpu[r_i[IW-1:0]];
                        r_rio[r_i[IW-1:0]-1'b1]  <= r_rio[r_i[IW-1:0]];
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_rcnt <= r_rcnt - 1'b1;
                        r_i    <= '0;
                        r_state <= (r_cmd.op == OP_TICK) ? S_SCAN : S_SUM_R;
                    end
                end
                S_SCAN: begin
                    if (r_i < r_bcnt) begin
                        if (w_io == '0 && r_rcnt < CW'(MAX_JOBS)) begin
                            r_rtag[r_rcnt[IW-1:0]] <= r_btag[r_i[IW-1:0]];
                            r_rcpu[r_rcnt[IW-1:0]] <= r_bcpu[r_i[IW-1:0]];
                            r_rio[r_rcnt[IW-1:0]]  <= '0;
                            r_rcnt <= r_rcnt + 1'b1;
                        end else begin
                            r_btag[r_kept[IW-1:0]] <= r_btag[r_i[IW-1:0]];
                            r_bcpu[r_kept[IW-1:0]] <= r_bcpu[r_i[IW-1:0]];
                            r_bio[r_kept[IW-1:0]]  <= w_io;
                            r_kept <= r_kept + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_bcnt <= r_kept;
                        r_i    <= '0;
                        r_state <= S_SUM_R;
                    end
                end
                S_SUM_R: begin
                    if (r_i < r_rcnt) begin
                        r_sum <= r_sum + SW'(r_rcpu[r_i[IW-1:0]]);
                        r_i   <= r_i + 1'b1;
                    end else begin
                        r_i <= '0;
                        r_state <= S_SUM_B;
                    end
                end
                S_SUM_B: begin
                    if (r_i < r_bcnt) begin
                        r_sum <= r_sum + SW'(r_bcpu[r_i[IW-1:0]]);
                        r_i   <= r_i + 1'b1;
                    end else begin
                        o_valid          <= 1'b1;
                        o_job_count      <= 5'(32'(r_rcnt) + 32'(r_bcnt));
                        o_total_cpu      <= 20'(r_sum);
                        o_finished_valid <= r_fin;
                        o_finished_tag   <= r_ftag;
                        o_rejected       <= r_rej;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (!i_stall) begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/ready_blocked_job_scheduler.sv
// Ready/blocked job scheduler top level: front queue plus back executor.
// The back part walks the stores one entry a cycle (shift, blocked scan,
// two summing passes). One beat is carried out at a time, and up to two
// beats queue in front meanwhile.
// Synchronous active-low reset empties both stores and the queue.
`include "ready_blocked_job_scheduler_assert.svh"
module ready_blocked_job_scheduler import rbjs_pkg::*; #(
    parameter int MAX_JOBS  = 16,
    parameter int TIME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_job_tag,
    input  logic [15:0] i_cpu_time,
    input  logic [15:0] i_io_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_job_count,
    output logic [19:0] o_total_cpu,
    output logic        o_finished_valid,
    output logic [7:0]  o_finished_tag,
    output logic        o_rejected
);
    logic cmd_valid, cmd_take;
    t_cmd cmd;

    rbjs_front #(.TIME_BITS(TIME_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode, .i_job_tag,
        .i_cpu_time, .i_io_time, .o_cmd_valid(cmd_valid), .o_cmd(cmd),
        .i_cmd_take(cmd_take)
    );

    rbjs_back #(.MAX_JOBS(MAX_JOBS), .TIME_BITS(TIME_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_take(cmd_take), .o_valid, .i_stall, .o_job_count, .o_total_cpu,
        .o_finished_valid, .o_finished_tag, .o_rejected
    );

    `RBJS_ASSERT_IMP(a_take_needs_cmd, i_clk, i_rst_n, cmd_take, cmd_valid)
    `RBJS_ASSERT_IMP(a_no_take_while_out, i_clk, i_rst_n, o_valid, !cmd_take)
    `RBJS_ASSERT_IMP(a_fin_tag_zero, i_clk, i_rst_n, o_valid && !o_finished_valid, o_finished_tag == 8'd0)
    `RBJS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, o_valid, 32'(o_job_count) <= MAX_JOBS)
endmodule

### tb/tb.sv
// Testbench for ready_blocked_job_scheduler: directed and random command beats.
// A scoreboard class predicts each result from its own copy of the job stores.
// Depends on rbjs_pkg and the scheduler RTL.
module tb;
    import rbjs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int JOBS = 16;

    typedef struct {
        logic [4:0]  job_count;
        logic [19:0] total_cpu;
        logic        fin_valid;
        logic [7:0]  fin_tag;
        logic        rejected;
    } t_status;

    class sched_scoreboard;
        logic [7:0]  rdy_tag[JOBS];
        logic [15:0] rdy_cpu[JOBS];
        logic [15:0] rdy_io[JOBS];
        int          n_rdy;
        logic [7:0]  blk_tag[JOBS];
        logic [15:0] blk_cpu[JOBS];
        logic [15:0] blk_io[JOBS];
        int          n_blk;
        t_status     pending[$];
        int          errors;

        function void clear();
            n_rdy = 0;
            n_blk = 0;
            errors = 0;
            pending.delete();
        endfunction

        function void drop_head();
            for (int i = 1; i < n_rdy; i++) begin
                rdy_tag[i-1] = rdy_tag[i];
                rdy_cpu[i-1] = rdy_cpu[i];
                rdy_io[i-1]  = rdy_io[i];
            end
            n_rdy--;
        endfunction

        function void note_command(logic [1:0] op, logic [7:0] tag,
                                   logic [15:0] cpu, logic [15:0] io);
            t_status s;
            int kept;
            logic [31:0] sum;
            logic [15:0] w;
            s = '{default: '0};
            case (op)
                OP_ADD: begin
                    if (n_rdy + n_blk >= JOBS) begin
                        s.rejected = 1'b1;
                    end else begin
                        rdy_tag[n_rdy] = tag;
                        rdy_cpu[n_rdy] = cpu;
                        rdy_io[n_rdy]  = io;
                        n_rdy++;
                    end
                end
                OP_BLOCK: begin
                    if (n_rdy == 0) begin
                        s.rejected = 1'b1;
                    end else begin
                        blk_tag[n_blk] = rdy_tag[0];
                        blk_cpu[n_blk] = rdy_cpu[0];
                        blk_io[n_blk]  = rdy_io[0];
                        n_blk++;
                        drop_head();
                    end
                end
                OP_TICK: begin
                    if (n_rdy > 0) begin
                        if (rdy_cpu[0] != 0) rdy_cpu[0]--;
                        if (rdy_cpu[0] == 0) begin
                            s.fin_valid = 1'b1;
                            s.fin_tag = rdy_tag[0];
                            drop_head();
                        end
                    end
                    kept = 0;
                    for (int i = 0; i < n_blk; i++) begin
                        w = (blk_io[i] != 16'd0) ? 16'(blk_io[i] - 16'd1) : 16'd0;
                        if (w == 0 && n_rdy < JOBS) begin
                            rdy_tag[n_rdy] = blk_tag[i];
                            rdy_cpu[n_rdy] = blk_cpu[i];
                            rdy_io[n_rdy]  = '0;
                            n_rdy++;
                        end else begin
                            blk_tag[kept] = blk_tag[i];
                            blk_cpu[kept] = blk_cpu[i];
                            blk_io[kept]  = w;
                            kept++;
                        end
                    end
                    n_blk = kept;
                end
                default: ;
            endcase
            sum = '0;
            for (int i = 0; i < n_rdy; i++) sum += 32'(rdy_cpu[i]);
            for (int i = 0; i < n_blk; i++) sum += 32'(blk_cpu[i]);
            s.job_count = 5'(n_rdy + n_blk);
            s.total_cpu = sum[19:0];
            pending.push_back(s);
        endfunction

        function void check_status(t_status got);
            t_status e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result count=%0d", $realtime, got.job_count);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.job_count !== e.job_count || got.total_cpu !== e.total_cpu ||
                got.fin_valid !== e.fin_valid || got.fin_tag !== e.fin_tag ||
                got.rejected !== e.rejected) begin
                $display("%0t: expected cnt=%0d cpu=%0d fin=%b/%0d rej=%b",
                         $realtime, e.job_count, e.total_cpu, e.fin_valid, e.fin_tag,
                         e.rejected);
                $display("%0t: actual   cnt=%0d cpu=%0d fin=%b/%0d rej=%b",
                         $realtime, got.job_count, got.total_cpu, got.fin_valid,
                         got.fin_tag, got.rejected);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = OP_QUERY;
    logic [7:0]  i_job_tag = '0;
    logic [15:0] i_cpu_time = '0;
    logic [15:0] i_io_time = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic [4:0]  o_job_count;
    logic [19:0] o_total_cpu;
    logic        o_finished_valid;
    logic [7:0]  o_finished_tag;
    logic        o_rejected;

    sched_scoreboard sb = new();
    bit long_hold = 1'b0;
    bit hold_done = 1'b0;

    ready_blocked_job_scheduler dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // One command beat; gaps are taken before raising valid.
    task automatic send_cmd(logic [1:0] op, logic [7:0] tag, logic [15:0] cpu,
                            logic [15:0] io, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_job_tag  <= tag;
        i_cpu_time <= cpu;
        i_io_time  <= io;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_command(op, tag, cpu, io);
    endtask

    task automatic send_random(bit gaps);
        int r;
        logic [15:0] c, w;
        r = $urandom_range(0, 99);
        c = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        w = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        // Ticks dominate so jobs retire and return; adds keep the stores busy.
        if (r < 35)      send_cmd(OP_ADD, 8'($urandom), c, w, gaps);
        else if (r < 55) send_cmd(OP_BLOCK, 8'($urandom), 16'($urandom), 16'($urandom), gaps);
        else if (r < 93) send_cmd(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom), gaps);
        else             send_cmd(OP_QUERY, 8'($urandom), 16'($urandom), 16'($urandom), gaps);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_status('{o_job_count, o_total_cpu, o_finished_valid,
                              o_finished_tag, o_rejected});
    end

    initial begin
        int g;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold && !hold_done) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_done = 1'b1;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0) begin
                i_stall <= 1'b1;
                repeat (g) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int n;
        sb.clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-queue cases, zero and full-scale times, fill to full.
        send_cmd(OP_BLOCK, 8'h00, 16'h0000, 16'h0000, 0);
        send_cmd(OP_TICK, 8'hff, 16'hffff, 16'hffff, 0);
        send_cmd(OP_QUERY, 8'haa, 16'h5555, 16'haaaa, 0);
        send_cmd(OP_ADD, 8'h00, 16'h0000, 16'h0000, 0);
        send_cmd(OP_ADD, 8'hff, 16'hffff, 16'hffff, 0);
        send_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 0);
        send_cmd(OP_BLOCK, 8'h00, 16'h0000, 16'h0000, 0);
        send_cmd(OP_ADD, 8'h5a, 16'h0001, 16'h0000, 0);
        send_cmd(OP_BLOCK, 8'h00, 16'h0000, 16'h0000, 0);
        send_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 0);
        for (int i = 0; i < 14; i++)
            send_cmd(OP_ADD, 8'(8'h10 + i), 16'hffff, 16'(i), 0);
        send_cmd(OP_ADD, 8'h77, 16'h0003, 16'h0003, 0);

        // Block the receiver for a long stretch while commands keep coming.
        long_hold = 1'b1;
        for (int i = 0; i < 20; i++) send_random(0);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        // Send 16 blocks to move the ready jobs into the blocked store, then 16 ticks.
        for (int i = 0; i < 16; i++) send_cmd(OP_BLOCK, 8'h00, 16'h0, 16'h0, 1);
        for (int i = 0; i < 16; i++) send_cmd(OP_TICK, 8'h00, 16'h0, 16'h0, 1);

        n = 0;
        while (n < 1000) begin
            send_random(n % 200 > 20);
            n++;
        end

        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/rbjs_pkg.sv
rtl/rbjs_front.sv
rtl/rbjs_back.sv
rtl/ready_blocked_job_scheduler.sv
tb/tb.sv
